### rtl/mvrd_pkg.sv
// Package: constants, codes and shared types of the matrix-vector row dot core.
`default_nettype none
package mvrd_pkg;

    localparam int MAX_ORDER    = 16;
    localparam int ELEMENT_BITS = 16;
    localparam int INDEX_BITS   = $clog2(MAX_ORDER);
    localparam int SIZE_BITS    = 5;
    localparam int ADDR_BITS    = 2 * INDEX_BITS;
    localparam int PROD_BITS    = 2 * ELEMENT_BITS;
    localparam int DOT_BITS     = 40;
    localparam int OP_BITS      = 2;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_ORDER);

    // operation codes
    localparam logic [OP_BITS-1:0] OP_LOAD_MATRIX = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_VECTOR = 2'd1;
    localparam logic [OP_BITS-1:0] OP_COMPUTE     = 2'd2;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_ROW   = 1'b1;

    typedef logic [OP_BITS-1:0]           op_t;
    typedef logic [INDEX_BITS-1:0]        index_t;
    typedef logic [SIZE_BITS-1:0]         size_t;
    typedef logic signed [ELEMENT_BITS-1:0] element_t;
    typedef logic signed [DOT_BITS-1:0]   dot_t;

    // control into the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } mac_ctl_t;

    // status out of the multiply-accumulate unit
    typedef struct packed {
        logic done;
        dot_t acc;
    } mac_sts_t;

endpackage
`default_nettype wire

### rtl/mvrd_if.sv
// Interfaces: command, result and configuration channels of the core.
`default_nettype none
interface mvrd_cmd_if;
    import mvrd_pkg::*;
    logic     valid;
    logic     ready;
    op_t      operation;
    index_t   row_index;
    index_t   column_index;
    element_t element_value;

    modport source (output valid, operation, row_index, column_index, element_value,
                    input ready);
    modport sink   (input valid, operation, row_index, column_index, element_value,
                    output ready);
endinterface

interface mvrd_rsp_if;
    import mvrd_pkg::*;
    logic   valid;
    logic   ready;
    index_t result_row;
    dot_t   dot_product;
    logic   status;

    modport source (output valid, result_row, dot_product, status, input ready);
    modport sink   (input valid, result_row, dot_product, status, output ready);
endinterface

interface mvrd_cfg_if;
    import mvrd_pkg::*;
    logic  valid;
    logic  ready;
    size_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/mvrd_mac.sv
// Multiply-accumulate unit: registered product, then 40-bit wrapping accumulate.
`default_nettype none
module mvrd_mac (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mvrd_pkg::mac_ctl_t ctl,
    input  wire mvrd_pkg::element_t a,
    input  wire mvrd_pkg::element_t b,
    output mvrd_pkg::mac_sts_t     sts
);
    import mvrd_pkg::*;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_valid_reg;
    logic                        prod_last_reg;
    dot_t                        acc_reg;
    logic                        done_reg;

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= a * b;
        end
    end

    // accumulate stage and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctl.valid;
            prod_last_reg  <= ctl.valid && ctl.last;
            done_reg       <= prod_valid_reg && prod_last_reg;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + DOT_BITS'(prod_reg);
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.acc  = acc_reg;

endmodule
`default_nettype wire

### rtl/matrix_vector_row_dot_core.sv
// Top level: element stores, row sequencer and result register of the row dot core.
// Load: the store is written at the edge the beat is accepted.
// Compute: n = min(size_in_use, 16) reads of the matrix and vector memories, one
// column per cycle, then two MAC stages; the sequencer drains until the MAC signals
// done, then loads the result register and returns to idle to take the next item. A
// row outside the size goes straight to loading its result; a held result stalls both.
// Reset: size_in_use returns to 16, control clears; stores hold garbage until written.
`default_nettype none
module matrix_vector_row_dot_core (
    input  wire logic clk,
    input  wire logic rst_n,
    mvrd_cmd_if.sink   cmd,
    mvrd_rsp_if.source rsp,
    mvrd_cfg_if.sink   cfg
);
    import mvrd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t     state_reg;
    size_t      size_reg;
    index_t     row_reg;
    index_t     col_reg;
    logic       status_reg;
    logic       rd_valid_reg;
    logic       rd_last_reg;
    logic       out_valid_reg;
    index_t     out_row_reg;
    dot_t       out_dot_reg;
    logic       out_status_reg;
    element_t   mat_rd_reg;
    element_t   vec_rd_reg;

    element_t   matrix_mem [MAX_ORDER*MAX_ORDER];
    element_t   vector_mem [MAX_ORDER];

    size_t      size_eff;
    logic       cmd_fire;
    logic       is_compute;
    logic       row_ok;
    logic       rd_en;
    logic       rd_last;
    logic       out_free;
    mac_ctl_t   mac_ctl;
    mac_sts_t   mac_sts;

    // saturate the size at the store order
    assign size_eff   = (size_reg > SIZE_BITS'(MAX_ORDER)) ? SIZE_BITS'(MAX_ORDER) : size_reg;
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign is_compute = (cmd.operation == OP_COMPUTE);
    assign row_ok     = ({1'b0, cmd.row_index} < size_eff);
    assign rd_en      = (state_reg == ST_RUN);
    assign rd_last    = ({1'b0, col_reg} == (size_eff - 1'b1));
    assign out_free   = !out_valid_reg || rsp.ready;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    // stores: writes only in idle, reads only while running, so no overlap on an entry
    always_ff @(posedge clk)
    begin
        if (cmd_fire && (cmd.operation == OP_LOAD_MATRIX))
        begin
            matrix_mem[{cmd.row_index, cmd.column_index}] <= cmd.element_value;
        end
        if (cmd_fire && (cmd.operation == OP_LOAD_VECTOR))
        begin
            vector_mem[cmd.column_index] <= cmd.element_value;
        end
        if (rd_en)
        begin
            mat_rd_reg <= matrix_mem[{row_reg, col_reg}];
            vec_rd_reg <= vector_mem[col_reg];
        end
    end

    // feed the MAC with the registered read data
    assign mac_ctl.clear = cmd_fire && is_compute;
    assign mac_ctl.valid = rd_valid_reg;
    assign mac_ctl.last  = rd_last_reg;

    mvrd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mat_rd_reg),
        .b     (vec_rd_reg),
        .sts   (mac_sts)
    );

    // sequencer, configuration register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= SIZE_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            status_reg     <= STATUS_OK;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_dot_reg    <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                size_reg <= cfg.data;
            end

            rd_valid_reg <= rd_en;
            rd_last_reg  <= rd_en && rd_last;

            // drop the result once taken, unless a new one loads in its place
            if (out_valid_reg && rsp.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire && is_compute)
                    begin
                        row_reg <= cmd.row_index;
                        col_reg <= '0;
                        if (row_ok)
                        begin
                            status_reg <= STATUS_OK;
                            state_reg  <= ST_RUN;
                        end
                        else
                        begin
                            status_reg <= STATUS_BAD_ROW;
                            state_reg  <= ST_FINISH;
                        end
                    end
                end
                ST_RUN:
                begin
                    // advance one column per cycle
                    col_reg <= col_reg + 1'b1;
                    if (rd_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (mac_sts.done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_row_reg    <= row_reg;
                        out_status_reg <= status_reg;
                        out_dot_reg    <= (status_reg == STATUS_BAD_ROW) ? '0 : mac_sts.acc;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_row  = out_row_reg;
    assign rsp.dot_product = out_dot_reg;
    assign rsp.status      = out_status_reg;

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the matrix-vector row dot core: stimulus, predictor and result checks.
`timescale 1ns / 1ps
module tb;
    import mvrd_pkg::*;

    localparam int  PHASES      = 10;
    localparam int  PHASE_ITEMS = 78;
    localparam int  SETTLE      = 24;
    localparam int  CYCLE_LIMIT = 400000;
    localparam op_t OP_UNUSED   = 2'd3;

    typedef struct {
        op_t      op;
        index_t   row;
        index_t   col;
        element_t value;
    } cmd_item_t;

    typedef struct {
        index_t row;
        dot_t   dot;
        logic   status;
    } dot_result_t;

    logic clk;
    logic rst_n;

    mvrd_cmd_if cmd_bus();
    mvrd_rsp_if rsp_bus();
    mvrd_cfg_if cfg_bus();

    matrix_vector_row_dot_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // pending commands and dot products still owed by the core
    cmd_item_t   cmd_backlog[$];
    dot_result_t dot_expect[$];
    cmd_item_t   next_beat;

    // generator view of which store entries hold data
    bit mat_loaded[MAX_ORDER][MAX_ORDER];
    bit vec_loaded[MAX_ORDER];
    int gen_count;

    // predictor copy of the stores and the size register
    element_t mat_shadow[MAX_ORDER][MAX_ORDER];
    element_t vec_shadow[MAX_ORDER];
    size_t    size_shadow;

    bit steady;
    int errors;
    int cycles;
    int n_loads;
    int n_dots;
    int n_bad_rows;
    int n_cfg;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic element_t rand_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            default: return element_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // queue one command and track which entries it fills
    task automatic push_item(input op_t op, input int row, input int col, input element_t value);
        cmd_item_t item;
        item.op    = op;
        item.row   = index_t'(row);
        item.col   = index_t'(col);
        item.value = value;
        cmd_backlog.push_back(item);
        if (op == OP_LOAD_MATRIX)
            mat_loaded[row][col] = 1'b1;
        else if (op == OP_LOAD_VECTOR)
            vec_loaded[col] = 1'b1;
        if (op != OP_UNUSED)
            gen_count++;
    endtask

    // fill any gaps of one row and the vector, refresh some entries, then ask for the row
    task automatic load_and_compute(input int row, input int eff);
        for (int j = 0; j < eff; j++)
            if (!vec_loaded[j] || $urandom_range(0, 5) == 0)
                push_item(OP_LOAD_VECTOR, $urandom_range(0, 15), j, rand_element());
        for (int j = 0; j < eff; j++)
            if (!mat_loaded[row][j] || $urandom_range(0, 3) == 0)
                push_item(OP_LOAD_MATRIX, row, j, rand_element());
        push_item(OP_COMPUTE, row, $urandom_range(0, 15), element_t'($urandom));
    endtask

    // hold until every command went out and every dot product came back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_bus.valid || dot_expect.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(input int value);
        wait_idle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= size_t'(value);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_phase(input int size_value, input int budget);
        int eff;
        int stop_at;
        int pick;
        eff     = (size_value > MAX_ORDER) ? MAX_ORDER : size_value;
        write_size(size_value);
        stop_at = gen_count + budget;
        while (gen_count < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if (eff > 0)
                    load_and_compute($urandom_range(0, eff - 1), eff);
                else
                    push_item(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                              rand_element());
            end
            else if (pick < 72)
            begin
                if (eff < MAX_ORDER)
                    push_item(OP_COMPUTE, $urandom_range(eff, 15), $urandom_range(0, 15),
                              rand_element());
                else
                    load_and_compute($urandom_range(0, eff - 1), eff);
            end
            else if (pick < 94)
                push_item($urandom_range(0, 1) ? OP_LOAD_VECTOR : OP_LOAD_MATRIX,
                          $urandom_range(0, 15), $urandom_range(0, 15), rand_element());
            else
                push_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                          rand_element());
        end
    endtask

    // command driver: advance to the next beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else if (!cmd_bus.valid || cmd_bus.ready)
        begin
            if (cmd_backlog.size() != 0 && !take_gap())
            begin
                next_beat = cmd_backlog.pop_front();
                cmd_bus.valid         <= 1'b1;
                cmd_bus.operation     <= next_beat.op;
                cmd_bus.row_index     <= next_beat.row;
                cmd_bus.column_index  <= next_beat.col;
                cmd_bus.element_value <= next_beat.value;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // result sink: drop ready at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= !take_gap();
    end

    // monitor: track config, predict on each command beat, check each result beat
    always @(posedge clk)
    begin
        dot_result_t want;
        dot_t        acc;
        logic signed [2*ELEMENT_BITS-1:0] prod;
        int          eff;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                size_shadow = cfg_bus.data;
                n_cfg++;
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                case (cmd_bus.operation)
                    OP_LOAD_MATRIX:
                    begin
                        mat_shadow[cmd_bus.row_index][cmd_bus.column_index] = cmd_bus.element_value;
                        n_loads++;
                    end
                    OP_LOAD_VECTOR:
                    begin
                        vec_shadow[cmd_bus.column_index] = cmd_bus.element_value;
                        n_loads++;
                    end
                    OP_COMPUTE:
                    begin
                        eff      = (size_shadow > MAX_ORDER) ? MAX_ORDER : int'(size_shadow);
                        want.row = cmd_bus.row_index;
                        if (int'(cmd_bus.row_index) >= eff)
                        begin
                            want.dot    = '0;
                            want.status = STATUS_BAD_ROW;
                            n_bad_rows++;
                        end
                        else
                        begin
                            acc = '0;
                            for (int j = 0; j < eff; j++)
                            begin
                                prod = mat_shadow[cmd_bus.row_index][j] * vec_shadow[j];
                                acc  = acc + prod;
                            end
                            want.dot    = acc;
                            want.status = STATUS_OK;
                            n_dots++;
                        end
                        dot_expect.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (dot_expect.size() == 0)
                    report_mismatch($sformatf("unexpected result for row %0d",
                                              rsp_bus.result_row));
                else
                begin
                    want = dot_expect.pop_front();
                    if (rsp_bus.result_row !== want.row)
                        report_mismatch($sformatf("result_row %0d, want %0d",
                                                  rsp_bus.result_row, want.row));
                    if (rsp_bus.dot_product !== want.dot)
                        report_mismatch($sformatf("row %0d dot_product %0d, want %0d",
                                                  want.row, rsp_bus.dot_product, want.dot));
                    if (rsp_bus.status !== want.status)
                        report_mismatch($sformatf("row %0d status %0b, want %0b",
                                                  want.row, rsp_bus.status, want.status));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results owed",
                     CYCLE_LIMIT, dot_expect.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int phase_sizes[PHASES];
        phase_sizes = '{16, 31, 2, 0, 1, 17, 16, 9, 0, 5};
        phase_sizes[8] = $urandom_range(0, 31);

        cmd_bus.valid         = 1'b0;
        cmd_bus.operation     = OP_LOAD_MATRIX;
        cmd_bus.row_index     = '0;
        cmd_bus.column_index  = '0;
        cmd_bus.element_value = '0;
        rsp_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.data          = '0;
        size_shadow           = SIZE_RESET;
        steady                = 1'b0;
        errors                = 0;
        cycles                = 0;
        gen_count             = 0;
        rst_n                 = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme products, rows outside the size, loads beyond the size
        write_size(1);
        push_item(OP_LOAD_VECTOR, 0, 0, 16'sh7fff);
        push_item(OP_LOAD_MATRIX, 0, 0, 16'sh7fff);
        push_item(OP_COMPUTE, 0, 0, '0);
        push_item(OP_LOAD_MATRIX, 0, 0, 16'sh8000);
        push_item(OP_LOAD_VECTOR, 15, 0, 16'sh8000);
        push_item(OP_COMPUTE, 0, 15, 16'sh7fff);
        push_item(OP_LOAD_VECTOR, 0, 0, 16'sh7fff);
        push_item(OP_COMPUTE, 0, 0, 16'sh8000);
        push_item(OP_COMPUTE, 1, 0, '0);
        push_item(OP_COMPUTE, 15, 15, -16'sd1);
        push_item(OP_UNUSED, 15, 15, -16'sd1);
        push_item(OP_LOAD_MATRIX, 15, 15, -16'sd1);
        push_item(OP_LOAD_VECTOR, 0, 15, 16'sd1);
        push_item(OP_LOAD_MATRIX, 0, 0, '0);
        push_item(OP_COMPUTE, 0, 0, '0);
        write_size(0);
        push_item(OP_COMPUTE, 0, 0, '0);
        push_item(OP_COMPUTE, 15, 0, '0);

        // random phases; one runs with no gaps on either side
        for (int p = 0; p < PHASES; p++)
        begin
            steady = (p == 6);
            run_phase(phase_sizes[p], PHASE_ITEMS);
        end
        wait_idle();
        steady = 1'b0;
        repeat (30) @(posedge clk);

        $display("covered %0d loads, %0d dot products, %0d out-of-range rows, %0d size writes",
                 n_loads, n_dots, n_bad_rows, n_cfg);
        $display("mismatches: %0d, cycles: %0d", errors, cycles);
        if (errors == 0 && dot_expect.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
